### sv/volume_rotate_scatter_address_core_macros.svh
`ifndef VOLUME_ROTATE_SCATTER_ADDRESS_CORE_MACROS_SVH
`define VOLUME_ROTATE_SCATTER_ADDRESS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define VRSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define VRSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/vrsa_pkg.sv
`default_nettype none

package vrsa_pkg;

  // Largest supported volume edge; larger programmed sizes saturate to it.
  localparam int MAX_DIM = 512;

  // Fixed field widths.
  localparam int DIM_FIELD_W = 10;
  localparam int COORD_W     = 9;
  localparam int VALUE_W     = 32;
  localparam int ADDR_W      = 27;
  localparam int COEF_W      = 16;
  localparam int FRAC_SHIFT  = 15;
  localparam int ROW_W       = 48;
  localparam int DIMS_W      = 30;

  // Derived datapath widths.
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CEN_W  = DIM_W + 2;
  localparam int PROD_W = CEN_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int N_W    = ACC_W - FRAC_SHIFT + 1;
  localparam int ZN_W   = DIM_W + 1 + N_W;
  localparam int ZYN_W  = 2 * DIM_W + 1 + N_W;
  localparam int SUM_W  = ZYN_W + 2;
  localparam int TOT_W  = 3 * DIM_W;

  // Register port.
  localparam int PADDR_W     = 6;
  localparam int PDATA_W     = 64;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;

  localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_DIMS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_DIMS   = 3'd4;

  localparam logic [ROW_W-1:0]  ROW0_RESET = 48'd16384;
  localparam logic [ROW_W-1:0]  ROW1_RESET = 48'd1073741824;
  localparam logic [ROW_W-1:0]  ROW2_RESET = 48'd70368744177664;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 30'd537395712;

  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] coef;
    logic [2:0][DIM_W-1:0]       src_dim;
    logic [2:0][DIM_W-1:0]       out_dim;
    logic [2*DIM_W-1:0]          zy;
    logic [TOT_W-1:0]            total;
  } cfg_t;

  typedef struct packed {
    logic                  live;
    logic [2:0][N_W-1:0]   n;
    logic [VALUE_W-1:0]    value;
  } rot_item_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_FIELD_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/vrsa_cfg.sv
`default_nettype none

module vrsa_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vrsa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vrsa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [vrsa_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output vrsa_pkg::cfg_t                     cfg
);

  logic [vrsa_pkg::ROW_W-1:0]   row [3];
  logic [vrsa_pkg::DIMS_W-1:0]  src_dims;
  logic [vrsa_pkg::DIMS_W-1:0]  out_dims;
  logic [2*vrsa_pkg::DIM_W-1:0] zy;
  logic [vrsa_pkg::TOT_W-1:0]   total;
  logic                         wr;
  logic [vrsa_pkg::REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[vrsa_pkg::PADDR_W-1:vrsa_pkg::REG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]   <= vrsa_pkg::ROW0_RESET;
      row[1]   <= vrsa_pkg::ROW1_RESET;
      row[2]   <= vrsa_pkg::ROW2_RESET;
      src_dims <= vrsa_pkg::DIMS_RESET;
      out_dims <= vrsa_pkg::DIMS_RESET;
    end else if (wr) begin
      case (idx)
        vrsa_pkg::REG_ROTATION_ROW0: row[0]   <= pwdata[vrsa_pkg::ROW_W-1:0];
        vrsa_pkg::REG_ROTATION_ROW1: row[1]   <= pwdata[vrsa_pkg::ROW_W-1:0];
        vrsa_pkg::REG_ROTATION_ROW2: row[2]   <= pwdata[vrsa_pkg::ROW_W-1:0];
        vrsa_pkg::REG_SOURCE_DIMS:   src_dims <= pwdata[vrsa_pkg::DIMS_W-1:0];
        vrsa_pkg::REG_OUTPUT_DIMS:   out_dims <= pwdata[vrsa_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vrsa_pkg::REG_ROTATION_ROW0: prdata = vrsa_pkg::PDATA_W'(row[0]);
      vrsa_pkg::REG_ROTATION_ROW1: prdata = vrsa_pkg::PDATA_W'(row[1]);
      vrsa_pkg::REG_ROTATION_ROW2: prdata = vrsa_pkg::PDATA_W'(row[2]);
      vrsa_pkg::REG_SOURCE_DIMS:   prdata = vrsa_pkg::PDATA_W'(src_dims);
      vrsa_pkg::REG_OUTPUT_DIMS:   prdata = vrsa_pkg::PDATA_W'(out_dims);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        cfg.coef[a][b] = row[a][b*vrsa_pkg::COEF_W +: vrsa_pkg::COEF_W];
      end
      cfg.src_dim[a] = vrsa_pkg::sat_dim(src_dims[a*vrsa_pkg::DIM_FIELD_W +:
                                                  vrsa_pkg::DIM_FIELD_W]);
      cfg.out_dim[a] = vrsa_pkg::sat_dim(out_dims[a*vrsa_pkg::DIM_FIELD_W +:
                                                  vrsa_pkg::DIM_FIELD_W]);
    end
    cfg.zy    = zy;
    cfg.total = total;
  end

  // Output plane size and volume size, registered in turn: zy from the output sizes, then total from zy.
  always_ff @(posedge clk) begin
    zy    <= cfg.out_dim[2] * cfg.out_dim[1];
    total <= cfg.out_dim[0] * zy;
  end

endmodule

`default_nettype wire

### sv/vrsa_rotate.sv
`default_nettype none

module vrsa_rotate (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vrsa_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_x,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_y,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_z,
  input  wire logic [vrsa_pkg::VALUE_W-1:0]  voxel_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output vrsa_pkg::rot_item_t                out_item
);

  logic [vrsa_pkg::COORD_W-1:0]       pin [3];
  logic                               src_ok;
  logic signed [vrsa_pkg::CEN_W-1:0]  cen_in [3];
  logic signed [vrsa_pkg::ACC_W-1:0]  sum_in [3];
  logic [vrsa_pkg::ACC_W-1:0]         mag [3];
  logic [vrsa_pkg::ACC_W-1:0]         rnd [3];
  logic [vrsa_pkg::N_W-1:0]           n_in [3];

  logic                               a_valid, b_valid, c_valid;
  logic                               a_live, b_live, c_live;
  logic [vrsa_pkg::VALUE_W-1:0]       a_value, b_value, c_value;
  logic signed [vrsa_pkg::CEN_W-1:0]  a_cen [3];
  logic signed [vrsa_pkg::PROD_W-1:0] b_prod [3][3];
  logic signed [vrsa_pkg::ACC_W-1:0]  c_acc [3];
  logic                               en_a, en_b, en_c, en_d;

  // Each stage moves on when it is empty or the stage after it moves.
  assign en_d     = !out_valid || !out_stall;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_stall = !en_a;

  assign pin[0] = src_x;
  assign pin[1] = src_y;
  assign pin[2] = src_z;

  // Centring in doubled units: 2p - (D - 1).
  always_comb begin
    src_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      src_ok    = src_ok && (32'(pin[a]) < 32'(cfg.src_dim[a]));
      cen_in[a] = $signed(vrsa_pkg::CEN_W'({pin[a], 1'b0}))
                - $signed(vrsa_pkg::CEN_W'(cfg.src_dim[a]))
                + vrsa_pkg::CEN_W'(1);
    end
  end

  // Sum of products plus the output centre (O - 1) * 2^14.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_in[a] = vrsa_pkg::ACC_W'(b_prod[a][0]) + vrsa_pkg::ACC_W'(b_prod[a][1])
                + vrsa_pkg::ACC_W'(b_prod[a][2])
                + (($signed(vrsa_pkg::ACC_W'(cfg.out_dim[a])) - vrsa_pkg::ACC_W'(1))
                   <<< (vrsa_pkg::FRAC_SHIFT - 1));
    end
  end

  // Round half away from zero on the magnitude.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a]  = c_acc[a][vrsa_pkg::ACC_W-1] ? vrsa_pkg::ACC_W'(-c_acc[a])
                                            : vrsa_pkg::ACC_W'(c_acc[a]);
      rnd[a]  = (mag[a] + (vrsa_pkg::ACC_W'(1) << (vrsa_pkg::FRAC_SHIFT - 1)))
                >> vrsa_pkg::FRAC_SHIFT;
      n_in[a] = c_acc[a][vrsa_pkg::ACC_W-1] ? -vrsa_pkg::N_W'(rnd[a])
                                            : vrsa_pkg::N_W'(rnd[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (en_d) out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_live  <= src_ok;
      a_value <= voxel_value;
      for (int a = 0; a < 3; a++) a_cen[a] <= cen_in[a];
    end
    if (en_b && a_valid) begin
      b_live  <= a_live;
      b_value <= a_value;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          b_prod[a][b] <= a_cen[b] * $signed(cfg.coef[a][b]);
        end
      end
    end
    if (en_c && b_valid) begin
      c_live  <= b_live;
      c_value <= b_value;
      for (int a = 0; a < 3; a++) c_acc[a] <= sum_in[a];
    end
    if (en_d && c_valid) begin
      out_item.live  <= c_live;
      out_item.value <= c_value;
      for (int a = 0; a < 3; a++) out_item.n[a] <= n_in[a];
    end
  end

endmodule

`default_nettype wire

### sv/vrsa_address.sv
`default_nettype none

module vrsa_address (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vrsa_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire vrsa_pkg::rot_item_t           in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vrsa_pkg::ADDR_W-1:0]        write_address,
  output logic [vrsa_pkg::VALUE_W-1:0]       write_value
);

  logic                               e_valid;
  logic                               e_live;
  logic [vrsa_pkg::VALUE_W-1:0]       e_value;
  logic signed [vrsa_pkg::N_W-1:0]    e_n2;
  logic signed [vrsa_pkg::ZN_W-1:0]   e_zn1;
  logic signed [vrsa_pkg::ZYN_W-1:0]  e_zyn0;
  logic signed [vrsa_pkg::SUM_W-1:0]  idx;
  logic                               idx_ok;
  logic                               en_e, en_f;

  assign en_f     = !out_valid || !out_stall;
  assign en_e     = !e_valid || en_f;
  assign in_stall = !en_e;

  assign idx = vrsa_pkg::SUM_W'(e_n2) + vrsa_pkg::SUM_W'(e_zn1)
             + vrsa_pkg::SUM_W'(e_zyn0);
  assign idx_ok = !idx[vrsa_pkg::SUM_W-1]
               && (idx[vrsa_pkg::SUM_W-2:0] < (vrsa_pkg::SUM_W - 1)'(cfg.total));

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_e) e_valid <= in_valid;
      // Requests outside either volume leave the pipeline here.
      if (en_f) out_valid <= e_valid && e_live && idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e && in_valid) begin
      e_live  <= in_item.live;
      e_value <= in_item.value;
      e_n2    <= $signed(in_item.n[2]);
      e_zn1   <= $signed({1'b0, cfg.out_dim[2]}) * $signed(in_item.n[1]);
      e_zyn0  <= $signed({1'b0, cfg.zy}) * $signed(in_item.n[0]);
    end
    if (en_f && e_valid) begin
      write_address <= idx[vrsa_pkg::ADDR_W-1:0];
      write_value   <= e_value;
    end
  end

endmodule

`default_nettype wire

### sv/volume_rotate_scatter_address_core.sv
// Nearest-neighbour scatter address generator for rotating a 3-D volume. Each
// request carries one source voxel (src_x, src_y, src_z, voxel_value); voxels
// outside the programmed source size are discarded. The rest are centred on the
// source volume in half-voxel units, rotated by the signed Q2.14 matrix held in
// rotation_row0..2, re-centred on the output volume, rounded half away from zero
// per axis, and turned into the linear address z + Z*y + Z*Y*x. A request whose
// address falls inside [0, X*Y*Z) of the output volume produces exactly one
// result (write_address, write_value); any other produces none. The block takes
// one request per clock while in_stall is low and passes it through stages: three
// for centring, the nine coefficient products and their sum, one for rounding,
// and two for the address products and the final add and bounds compare, the
// last of which is the output register. Stages with no request in them close up
// under a stalled output, so requests keep being taken until every stage is full.
// Registers sit on the APB port at byte address 8*i with 64-bit data; sizes above
// 512 read back as written but act as 512. Program them only while the pipeline
// is empty; the derived plane and volume sizes are registered after the last write.
`default_nettype none

module volume_rotate_scatter_address_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_x,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_y,
  input  wire logic [vrsa_pkg::COORD_W-1:0]  src_z,
  input  wire logic [vrsa_pkg::VALUE_W-1:0]  voxel_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vrsa_pkg::ADDR_W-1:0]        write_address,
  output logic [vrsa_pkg::VALUE_W-1:0]       write_value,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vrsa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vrsa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [vrsa_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  `include "volume_rotate_scatter_address_core_macros.svh"

  vrsa_pkg::cfg_t      cfg;
  vrsa_pkg::rot_item_t rot_item;
  logic                rot_valid;
  logic                rot_stall;

  vrsa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Centring, rotation and rounding.
  vrsa_rotate u_rotate (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .src_x       (src_x),
    .src_y       (src_y),
    .src_z       (src_z),
    .voxel_value (voxel_value),
    .out_valid   (rot_valid),
    .out_stall   (rot_stall),
    .out_item    (rot_item)
  );

  // Linear address, volume bounds check and the output register.
  vrsa_address u_address (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (rot_valid),
    .in_stall      (rot_stall),
    .in_item       (rot_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_address (write_address),
    .write_value   (write_value)
  );

  // A delivered address always lies inside the output volume.
  `VRSA_ASSERT_IMPL(a_addr_in_volume, out_valid, (vrsa_pkg::TOT_W'(write_address) < cfg.total), "write_address outside the output volume")

  // Requests are refused only when every stage is full behind a stalled result.
  `VRSA_ASSERT_IMPL(a_stall_only_when_full, in_stall, (out_valid && out_stall), "input stalled while the pipeline has room")

  // A write to the source sizes reaches the datapath on the next cycle.
  `VRSA_ASSERT_NEXT(a_src_dims_written, (psel && penable && pwrite && (paddr[vrsa_pkg::PADDR_W-1:vrsa_pkg::REG_IDX_LSB] == vrsa_pkg::REG_SOURCE_DIMS)), (cfg.src_dim[0] == vrsa_pkg::sat_dim($past(pwdata[vrsa_pkg::DIM_FIELD_W-1:0]))), "source size write not applied")

endmodule

`default_nettype wire
